// ===== rtl/apt_pkg.sv =====
// Shared types and constants for the aging presence table.
// Used by every module of the block; depends on nothing.
package apt_pkg;

  localparam int unsigned IdentW = 16;
  localparam int unsigned IndexW = 31;
  localparam int unsigned TimeW  = 32;

  localparam logic [TimeW-1:0] TimeoutRst = 32'd10000;

  // Codes of the kind field of an input item.
  localparam logic KindMsg  = 1'b0;
  localparam logic KindPoll = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IndexW-1:0] msg_index;
    logic              relevant;
    logic [IdentW-1:0] ident;
    logic              is_set;
    logic [TimeW-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [IdentW-1:0] shown_ident;
    logic              any_active;
    logic              restarted;
  } out_item_t;

  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [TimeW-1:0]  seen;
  } slot_entry_t;

  // Index bookkeeping status handed to the sequencer.
  typedef struct packed {
    logic fresh;    // message index is above the last committed one
    logic restart;  // an index restart was seen during this poll
  } idx_info_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } apt_state_e;

endpackage

// ===== rtl/apt_slot_mem.sv =====
// Slot memory holding identifier and last-seen time per slot.
// One write port, one read port with registered data; uses apt_pkg.
module apt_slot_mem
  import apt_pkg::*;
#(
  parameter int unsigned SLOTS = 32,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic        clk_i,
  input  logic        re_i,
  input  logic [AW-1:0] raddr_i,
  input  logic        we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_entry_t wdata_i,
  output slot_entry_t rdata_o
);

  slot_entry_t mem [SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/apt_index_track.sv =====
// Sequence index bookkeeping: last committed index, highest index of the
// current poll and the restart flag. Uses apt_pkg.
module apt_index_track
  import apt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output idx_info_t info_o
);

  logic [IndexW-1:0] last_q, last_d, high_q, high_d;
  logic              last_vld_q, last_vld_d, high_vld_q, high_vld_d;
  logic              saw_lower_q, saw_lower_d;
  logic              stale, lower;

  // An index of minus one is kept as a cleared valid flag.
  assign stale = last_vld_q && (item_i.msg_index <= last_q);
  assign lower = last_vld_q && (item_i.msg_index < last_q);

  assign info_o.fresh   = !stale;
  assign info_o.restart = saw_lower_q;

  always_comb begin
    last_d      = last_q;
    last_vld_d  = last_vld_q;
    high_d      = high_q;
    high_vld_d  = high_vld_q;
    saw_lower_d = saw_lower_q;
    if (fire_i) begin
      if (item_i.kind == KindPoll) begin
        if (saw_lower_q) begin
          last_vld_d = 1'b0;
          high_vld_d = 1'b0;
        end else begin
          last_d     = high_q;
          last_vld_d = high_vld_q;
        end
        saw_lower_d = 1'b0;
      end else if (stale) begin
        if (lower) begin
          saw_lower_d = 1'b1;
        end
      end else if (!high_vld_q || (item_i.msg_index > high_q)) begin
        high_d     = item_i.msg_index;
        high_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      last_vld_q  <= 1'b0;
      high_q      <= '0;
      high_vld_q  <= 1'b0;
      saw_lower_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      last_vld_q  <= last_vld_d;
      high_q      <= high_d;
      high_vld_q  <= high_vld_d;
      saw_lower_q <= saw_lower_d;
    end
  end

endmodule

// ===== rtl/aging_presence_table.sv =====
// Aging presence table: top level with the slot scan sequencer.
// Depends on apt_pkg, apt_slot_mem and apt_index_track.
//
// The block keeps up to SLOTS active identifiers, each with the time it was
// last seen, in a synchronous slot memory; a flip-flop occupancy bit per slot
// marks which entries hold an identifier, so reset and an index restart empty
// the table at once. A message transfer whose index is stale, or that is not
// relevant or names identifier zero, only updates the index bookkeeping.
// A fresh relevant message scans every slot, one memory read per cycle, and
// then writes the refreshed or inserted entry, or drops the entry on a clear.
// An end-of-poll transfer commits or restarts the index, then scans every
// slot to age out entries whose wrapping age reaches timeout_ms, and loads
// the result register once it is free. The result register lets the next
// input transfer be accepted while the last result waits. The block takes
// one item at a time; the slot scan through the single memory read port
// sets its pace. timeout_ms is written through timeout_we_i and should only
// change while the block is idle.
module aging_presence_table
  import apt_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              timeout_we_i,
  input  logic [TimeW-1:0]  timeout_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);

  apt_state_e state_q, state_d;

  in_item_t          item_q;
  logic [TimeW-1:0]  timeout_q;
  logic [SLOTS-1:0]  occ_q, occ_d;

  // Read issue side of the scan.
  logic [AW-1:0] addr_q, addr_d;
  logic          iss_q, iss_d;
  // Read data side: the slot whose data arrives this cycle.
  logic [AW-1:0] rd_idx_q;
  logic          rd_vld_q;

  // Scan results.
  logic          hit_q, hit_d, free_q, free_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [IdentW-1:0] shown_q, shown_d;
  logic          shown_vld_q, shown_vld_d;
  logic          restart_q, restart_d;

  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          in_fire;
  logic          rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;
  slot_entry_t   rdata;
  idx_info_t     idx_info;
  logic [TimeW-1:0] age;
  logic          occ_hit;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  apt_index_track u_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_data_i),
    .info_o (idx_info)
  );

  apt_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  assign rd_en   = (state_q == StScan) && iss_q;
  assign occ_hit = occ_q[rd_idx_q];
  // Wrapping age of the slot being examined.
  assign age     = item_q.now_ms - rdata.seen;

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    addr_d      = addr_q;
    iss_d       = iss_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    shown_d     = shown_q;
    shown_vld_d = shown_vld_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wdata   = '{ident: item_q.ident, seen: item_q.now_ms};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          addr_d      = '0;
          iss_d       = 1'b1;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          shown_vld_d = 1'b0;
          shown_d     = '0;
          if (in_data_i.kind == KindPoll) begin
            // End of poll: a restart empties the table before aging.
            restart_d = idx_info.restart;
            if (idx_info.restart) begin
              occ_d = '0;
            end
            state_d = StScan;
          end else if (idx_info.fresh && in_data_i.relevant &&
                       (in_data_i.ident != '0)) begin
            state_d = StScan;
          end
        end
      end

      StScan: begin
        if (iss_q) begin
          addr_d = addr_q + AW'(1);
          if (addr_q == LastSlot) begin
            iss_d = 1'b0;
          end
        end
        if (rd_vld_q) begin
          if (item_q.kind == KindPoll) begin
            if (occ_hit) begin
              if (age >= timeout_q) begin
                occ_d[rd_idx_q] = 1'b0;
              end else if (!shown_vld_q) begin
                shown_vld_d = 1'b1;
                shown_d     = rdata.ident;
              end
            end
          end else begin
            if (occ_hit && (rdata.ident == item_q.ident) && !hit_q) begin
              hit_d     = 1'b1;
              hit_idx_d = rd_idx_q;
            end
            if (!occ_hit && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = rd_idx_q;
            end
          end
          if (rd_idx_q == LastSlot) begin
            state_d = StFinish;
          end
        end
      end

      StFinish: begin
        if (item_q.kind == KindPoll) begin
          // Wait until the result register can take the new result.
          if (!out_valid_q || out_ready_i) begin
            out_valid_d       = 1'b1;
            out_d.shown_ident = shown_q;
            out_d.any_active  = shown_vld_q;
            out_d.restarted   = restart_q;
            state_d           = StIdle;
          end
        end else begin
          if (item_q.is_set) begin
            if (hit_q) begin
              mem_we = 1'b1;
            end else if (free_q) begin
              mem_we          = 1'b1;
              mem_waddr       = free_idx_q;
              occ_d[free_idx_q] = 1'b1;
            end
          end else if (hit_q) begin
            occ_d[hit_idx_q] = 1'b0;
          end
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      iss_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= TimeoutRst;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
      if (timeout_we_i) begin
        timeout_q <= timeout_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    addr_q      <= addr_d;
    rd_idx_q    <= addr_q;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    shown_q     <= shown_d;
    shown_vld_q <= shown_vld_d;
    restart_q   <= restart_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
